>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the indexed list block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/core/iil_pkg.sv
// Package for the indexed list block: request modes, status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package iil_pkg;

	// Field widths of the item payloads.
	localparam int ModeW   = 3;
	localparam int PosW    = 9;
	localparam int ValueW  = 32;
	localparam int StatusW = 2;
	localparam int LenOutW = 9;

	// Request kinds.
	typedef enum logic [ModeW-1:0] {
		MODE_READ     = 3'd0,
		MODE_INS_HEAD = 3'd1,
		MODE_INS_TAIL = 3'd2,
		MODE_INS_AT   = 3'd3,
		MODE_DELETE   = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [StatusW-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,
		S_PUT  = 5'b00100,
		S_DEL  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

endpackage

>>> rtl/core/indexed_list_insert_delete.sv
// Ordered list of up to CAPACITY values held in one synchronous memory in list order.
// A read passes the finish state and then the output register before m_tvalid rises. An insert
// at position p shifts the entries from the tail down to p and then writes the value; a delete at p
// shifts the entries above p down one place. One item at a time: a shift reads one entry per cycle
// and writes it on the separate write port. Reset empties the list at once (length zero);
// the value memory is not cleared and needs no clearing pass. Uses iil_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_list_insert_delete
	import iil_pkg::*;
#(
	parameter int CAPACITY   = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: mode [2:0], position [11:3], new_value [43:12], zeros [47:44]
	input  logic [47:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: read_value [31:0], status [33:32], length_now [42:34], zeros [47:43]
	output logic [47:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = (LW > PosW) ? LW : PosW;

	// Input item fields.
	logic [ModeW-1:0]         mode_in;
	logic [PosW-1:0]          pos_in;
	logic signed [ValueW-1:0] new_value_in;

	assign mode_in      = s_tdata[2:0];
	assign pos_in       = s_tdata[11:3];
	assign new_value_in = s_tdata[43:12];

	// Control registers.
	state_t          state_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   cur_q;
	logic [LW-1:0]   pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	status_t         status_q;
	logic            rd_ok_q;
	logic            wpend_s1;
	logic [AW-1:0]   waddr_s1;

	// Memory and its registered read data.
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;

	// Output register.
	logic                      m_valid_q;
	logic signed [ValueW-1:0]  out_value_q;
	status_t                   out_status_q;
	logic [LenOutW-1:0]        out_len_q;

	logic                  accept;
	logic                  out_free;
	logic [LW-1:0]         cur_m1;
	logic [CW-1:0]         pos_ext;
	logic [CW-1:0]         len_ext;
	logic [CW-1:0]         tgt;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic signed [63:0]    rd_wide;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign cur_m1   = cur_q - LW'(1);
	assign pos_ext  = CW'(pos_in);
	assign len_ext  = CW'(len_q);
	assign rd_wide  = 64'($signed(rd_data_q));

	// Target position of an insert request.
	always_comb begin
		case (mode_in)
			MODE_INS_HEAD: tgt = '0;
			MODE_INS_TAIL: tgt = len_ext;
			default:       tgt = pos_ext;
		endcase
	end

	// Memory port control: read ahead of the shift, write each entry in the cycle after its read.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(pos_in);
		case (state_q)
			S_IDLE: begin
				rd_en = accept && (mode_in == MODE_READ);
			end
			S_INS: begin
				rd_en   = (cur_q > pos_q);
				rd_addr = cur_m1[AW-1:0];
			end
			S_DEL: begin
				rd_en   = (cur_q < len_q);
				rd_addr = cur_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		if (state_q == S_PUT) begin
			wr_en   = 1'b1;
			wr_addr = pos_q[AW-1:0];
			wr_data = val_q;
		end else begin
			wr_en   = wpend_s1;
			wr_addr = waddr_s1;
			wr_data = rd_data_q;
		end
	end

	// Value memory with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			cur_q    <= '0;
			pos_q    <= '0;
			status_q <= ST_DONE;
			rd_ok_q  <= 1'b0;
			wpend_s1 <= 1'b0;
			waddr_s1 <= '0;
		end else begin
			// Every shift read is followed in the next cycle by its write.
			wpend_s1 <= rd_en && (state_q != S_IDLE);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ok_q <= (mode_in == MODE_READ) && (pos_ext < len_ext);
						case (mode_in)
							MODE_READ: begin
								status_q <= (pos_ext < len_ext) ? ST_DONE : ST_RANGE;
								state_q  <= S_FIN;
							end
							MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AT: begin
								if (tgt > len_ext) begin
									status_q <= ST_RANGE;
									state_q  <= S_FIN;
								end else if (len_q == LW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									cur_q    <= len_q;
									pos_q    <= LW'(tgt);
									len_q    <= len_q + LW'(1);
									status_q <= ST_DONE;
									state_q  <= S_INS;
								end
							end
							MODE_DELETE: begin
								if (pos_ext >= len_ext) begin
									status_q <= ST_RANGE;
									state_q  <= S_FIN;
								end else begin
									pos_q    <= LW'(pos_ext);
									cur_q    <= LW'(pos_ext + CW'(1));
									status_q <= ST_DONE;
									state_q  <= S_DEL;
								end
							end
							default: begin
								status_q <= ST_RANGE;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_INS: begin
					// Move entries one place up, from the tail down to the target.
					if (cur_q > pos_q) begin
						waddr_s1 <= cur_q[AW-1:0];
						cur_q    <= cur_m1;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= S_FIN;
				end
				S_DEL: begin
					// Move entries one place down, from above the target up to the tail.
					if (cur_q < len_q) begin
						waddr_s1 <= cur_m1[AW-1:0];
						cur_q    <= cur_q + LW'(1);
					end else begin
						len_q   <= len_q - LW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Store the new value zero-extended or truncated to the memory width.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= DATA_WIDTH'($unsigned(new_value_in));
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded when a result item leaves the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_value_q  <= rd_ok_q ? rd_wide[ValueW-1:0] : '0;
			out_status_q <= status_q;
			out_len_q    <= LenOutW'(len_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, out_len_q, out_status_q, out_value_q};

	// Checks on the sequencer.
	`ASSERT_IMP(a_len_bound, 1'b1, len_q <= LW'(CAPACITY))
	`ASSERT_IMP(a_no_write_idle, state_q == S_IDLE, !wr_en)
	`ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE)
	`ASSERT_NXT(a_fin_presents, state_q == S_FIN && out_free, m_tvalid)

endmodule
